// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the converter modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/sitoa_pkg.sv
// ---------------------------------------------------------------------------
// sitoa_pkg - shared types and constants
// Widths, character codes, reciprocal constant and the job word passed
// from the front stage through the queue to the digit engine.
// ---------------------------------------------------------------------------
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = 10;
    localparam int NDIG_W      = 4;   // holds 0..MAX_DIGITS and indexes the digit store
    localparam int PROD_W      = 2 * VALUE_W;

    // n / 10 == (n * RECIP_10) >> RECIP_SHIFT for every 32-bit unsigned n
    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // classified word: sign and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUB,
        BK_SIGN,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

// File: src/sitoa_front.sv
// ---------------------------------------------------------------------------
// sitoa_front - input stage
// Takes a word, splits off the sign and forms the unsigned magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module sitoa_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    output logic                                   o_full,
    input  wire logic signed [sitoa_pkg::VALUE_W-1:0] i_value,
    output logic                                   o_job_valid,
    input  wire logic                              i_job_ready,
    output sitoa_pkg::t_job                        o_job
);
    import sitoa_pkg::*;

    logic r_valid;
    t_job r_job;
    logic w_take;

    // stage is free when empty or draining into the queue this cycle
    assign o_full      = r_valid && !i_job_ready;
    assign w_take      = i_push && !o_full;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    // sign and magnitude; most negative value wraps to 2^31 unsigned
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job.neg <= i_value[VALUE_W-1];
            r_job.mag <= i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value))
                                            : VALUE_W'(i_value);
        end
    end

endmodule

`default_nettype wire

// File: src/sitoa_queue.sv
// ---------------------------------------------------------------------------
// sitoa_queue - short job queue
// Decouples the input stage from the digit engine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sitoa_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_ready,
    input  wire sitoa_pkg::t_job i_job,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output sitoa_pkg::t_job      o_job
);
    import sitoa_pkg::*;

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;
    assign o_job   = r_entry[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    `AST_CLK(a_q_level, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `AST_CLK(a_q_drop, i_clk, i_rst_n, !(i_push && !o_ready) || !i_pop || o_valid, "queue write lost while full")

endmodule

`default_nettype wire

// File: src/sitoa_back.sv
// ---------------------------------------------------------------------------
// sitoa_back - digit engine
// Peels decimal digits off the magnitude by reciprocal multiply, stores
// them, then plays out the sign and digits most significant first.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sitoa_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    output logic                               o_job_ready,
    input  wire sitoa_pkg::t_job               i_job,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [sitoa_pkg::CHAR_W-1:0]       o_character,
    output logic                               o_is_last
);
    import sitoa_pkg::*;

    t_back_state        r_state, n_state;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic [PROD_W-1:0]  r_prod;
    logic               r_neg, n_neg;
    logic [NDIG_W-1:0]  r_nd, n_nd;
    logic [NDIG_W-1:0]  r_idx, n_idx;
    logic [DIGIT_W-1:0] r_digits [MAX_DIGITS];

    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;
    logic               w_load;

    logic [QUOT_W-1:0]  w_quot;
    logic [VALUE_W-1:0] w_times10;
    logic [VALUE_W-1:0] w_rem;
    logic               w_slot;

    // quotient and remainder from the registered product
    assign w_quot    = r_prod[PROD_W-1 -: QUOT_W];
    assign w_times10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_rem     = r_mag - w_times10;

    // output register can take a word when empty or being popped
    assign w_slot      = !r_out_valid || i_pop;
    assign o_empty     = !r_out_valid;
    assign o_character = r_out_char;
    assign o_is_last   = r_out_last;

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_nd        = r_nd;
        n_idx       = r_idx;
        o_job_ready = 1'b0;
        w_load      = 1'b0;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_pop;
        unique case (r_state)
            BK_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_mag   = i_job.mag;
                    n_neg   = i_job.neg;
                    n_nd    = '0;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_SUB;
            end
            BK_SUB: begin
                n_mag = VALUE_W'(w_quot);
                n_nd  = r_nd + 1'b1;
                if (w_quot == '0) begin
                    n_idx   = r_nd;
                    n_state = r_neg ? BK_SIGN : BK_EMIT;
                end else begin
                    n_state = BK_MUL;
                end
            end
            BK_SIGN: begin
                if (w_slot) begin
                    w_load     = 1'b1;
                    n_out_char = CHAR_MINUS;
                    n_out_last = 1'b0;
                    n_state    = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_slot) begin
                    w_load     = 1'b1;
                    n_out_char = CHAR_ZERO + CHAR_W'(r_digits[r_idx]);
                    n_out_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_nd       <= n_nd;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (r_state == BK_MUL) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP_10);
        end
        if (r_state == BK_SUB) begin
            r_digits[r_nd] <= w_rem[DIGIT_W-1:0];
        end
    end

    `AST_CLK(a_bk_ndig, i_clk, i_rst_n, r_state != BK_SUB || r_nd < NDIG_W'(MAX_DIGITS), "digit store overrun")
    `AST_CLK(a_bk_last, i_clk, i_rst_n, !(r_out_valid && r_out_last) || (r_out_char >= CHAR_ZERO && r_out_char <= CHAR_NINE), "last word is not a digit")
    `AST_ALWAYS(a_bk_sub, i_clk, r_state == BK_SUB |=> $past(r_state) == BK_SUB, "divide step out of order")

endmodule

`default_nettype wire

// File: src/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii - signed 32-bit integer to decimal ASCII
// Channel   Dir  Handshake       Payload
// value     in   i_push / o_full i_value[31:0] signed
// text      out  o_empty / i_pop o_character[7:0], o_is_last
//
// Each value yields 1 to 11 words: optional '-', then digits, last flagged.
// Each digit is extracted by a reciprocal multiply, then subtract-and-store;
// once all digits are stored, the sign if any and the digits are played
// out most significant first, holding while the output word is full and
// not popped. The engine takes a new value only when it is idle.
// A two-entry queue lets new values be taken while the engine is busy.
// Synchronous active-low reset clears all handshake state; no clear pass.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_push,
    output logic                                      o_full,
    input  wire logic signed [sitoa_pkg::VALUE_W-1:0] i_value,
    output logic                                      o_empty,
    input  wire logic                                 i_pop,
    output logic [sitoa_pkg::CHAR_W-1:0]              o_character,
    output logic                                      o_is_last
);
    import sitoa_pkg::*;

    logic fr_valid;
    logic fr_ready;
    t_job fr_job;
    logic bk_valid;
    logic bk_ready;
    t_job bk_job;

    // input stage: sign split and magnitude
    sitoa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_value     (i_value),
        .o_job_valid (fr_valid),
        .i_job_ready (fr_ready),
        .o_job       (fr_job)
    );

    // job queue
    sitoa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .o_ready (fr_ready),
        .i_job   (fr_job),
        .o_valid (bk_valid),
        .i_pop   (bk_ready),
        .o_job   (bk_job)
    );

    // digit engine and output register
    sitoa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (bk_valid),
        .o_job_ready (bk_ready),
        .i_job       (bk_job),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_character (o_character),
        .o_is_last   (o_is_last)
    );

endmodule

`default_nettype wire
